@@ design/dws_pkg.sv @@
package dws_pkg;

	localparam int ID_W        = 10;
	localparam int TAG_W       = 4;
	localparam int ENT_W       = ID_W + TAG_W;
	localparam int REQ_W       = 2;
	localparam int STS_W       = 2;
	localparam int DEPTH_OUT_W = 7;
	localparam int TOTAL_W     = 32;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 88;

	localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_DIRTY = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd2;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic slot_free;
	} sts_t;

endpackage

@@ design/dedup_worklist_stack_top.sv @@
// deduplicating work stack
// requests enter on the s_axis channel: tuser carries the request kind (push, pop,
// peek) and tdata the thing id, circuit tag and bottom-insert flag. every request
// gives exactly one result on the m_axis channel: tuser carries the status, tdata
// the popped or peeked entry, the depth after the request and the push and pop
// totals.
// a request is accepted in the idle state and executed in the execute state, which
// waits while a result still sits untaken; no new request is taken until it has
// executed. execution waits for the dirty-mark read, which the bitmap registers.
// the entries live in a shift register with the top at a fixed place, so a push
// at the bottom or on top and a pop all finish in the execute state.
// after reset the dirty bitmap is swept clear, one mark a cycle, over all ITEM_COUNT
// marks; s_axis_tready stays low during the sweep.
// a finished result sits in the output register; the next request is still
// accepted, but it executes only once the waiting result has been taken.
module dedup_worklist_stack_top #(
	parameter int STACK_DEPTH = 64,
	parameter int ITEM_COUNT  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// item_id, circuit_tag, push_at_bottom, zero pad
	input  logic [15:0] s_axis_tdata,
	// req_type
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_item_id, out_circuit_tag, depth_now, pushes_total, pops_total, zero pad
	output logic [87:0] m_axis_tdata,
	// status
	output logic [1:0]  m_axis_tuser
);

	dws_pkg::cmd_t cmd;
	dws_pkg::sts_t sts;

	dws_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	dws_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.ITEM_COUNT  (ITEM_COUNT)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_axis_tdata),
		.s_tuser (s_axis_tuser),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_tdata (m_axis_tdata),
		.m_tuser (m_axis_tuser)
	);

endmodule

@@ design/dws_ram.sv @@
module dws_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/dws_ctrl.sv @@
module dws_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_valid,
	output logic          s_ready,
	input  dws_pkg::sts_t sts,
	output dws_pkg::cmd_t cmd
);

	dws_pkg::state_t state_q;
	dws_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dws_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dws_pkg::ST_CLEAR: begin
				if (sts.clr_last) begin
					state_nxt = dws_pkg::ST_IDLE;
				end
			end
			dws_pkg::ST_IDLE: begin
				if (s_valid) begin
					state_nxt = dws_pkg::ST_EXEC;
				end
			end
			dws_pkg::ST_EXEC: begin
				if (sts.slot_free) begin
					state_nxt = dws_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = dws_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		s_ready    = 1'b0;
		cmd.clear  = 1'b0;
		cmd.accept = 1'b0;
		cmd.exec   = 1'b0;
		case (state_q)
			dws_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			dws_pkg::ST_IDLE: begin
				s_ready    = 1'b1;
				cmd.accept = s_valid;
			end
			dws_pkg::ST_EXEC: begin
				cmd.exec = sts.slot_free;
			end
			default: begin
				s_ready = 1'b0;
			end
		endcase
	end

endmodule

@@ design/dws_datapath.sv @@
module dws_datapath #(
	parameter int STACK_DEPTH = 64,
	parameter int ITEM_COUNT  = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dws_pkg::cmd_t                   cmd,
	output dws_pkg::sts_t                   sts,
	input  logic [dws_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [dws_pkg::REQ_W-1:0]       s_tuser,
	output logic                            m_valid,
	input  logic                            m_ready,
	output logic [dws_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [dws_pkg::STS_W-1:0]       m_tuser
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int MW = $clog2(ITEM_COUNT);
	localparam int IW = dws_pkg::ID_W;
	localparam int TW = dws_pkg::TAG_W;
	localparam int EW = dws_pkg::ENT_W;
	localparam int DEPTH_PAD = dws_pkg::DEPTH_OUT_W;

	function automatic logic [MW-1:0] mark_of(input logic [IW-1:0] id);
		logic [IW:0] r;
		r = {1'b0, id};
		for (int k = IW - 1; k >= 0; k--) begin
			if ((ITEM_COUNT << k) < (1 << IW)) begin
				if (r >= (ITEM_COUNT << k)) begin
					r = r - (IW + 1)'(ITEM_COUNT << k);
				end
			end
		end
		return MW'(r);
	endfunction

	// request held during execution
	logic [dws_pkg::REQ_W-1:0] req_q;
	logic [IW-1:0]             id_q;
	logic [TW-1:0]             tag_q;
	logic                      bot_q;
	logic [MW-1:0]             midx_q;

	logic [EW-1:0]             ent_q [STACK_DEPTH];
	logic [CW-1:0]             cnt_q;
	logic [dws_pkg::TOTAL_W-1:0] pushes_q;
	logic [dws_pkg::TOTAL_W-1:0] pops_q;
	logic [MW-1:0]             clr_q;

	logic                      m_valid_q;
	logic [dws_pkg::STS_W-1:0] res_sts_q;
	logic [IW-1:0]             res_id_q;
	logic [TW-1:0]             res_tag_q;

	logic                      ram_we;
	logic [MW-1:0]             ram_waddr;
	logic                      ram_wdata;
	logic                      dirty;

	logic                      empty;
	logic                      full;
	logic                      push_ok;
	logic                      pop_ok;
	logic [dws_pkg::STS_W-1:0] sts_nxt;
	logic                      show_top;
	logic [EW-1:0]             new_ent;
	logic [CW+DEPTH_PAD-1:0]   depth_wide;

	assign new_ent = {id_q, tag_q};
	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CW'(STACK_DEPTH));
	assign push_ok = (req_q == dws_pkg::REQ_PUSH) && !dirty && !full;
	assign pop_ok  = (req_q == dws_pkg::REQ_POP) && !empty;
	assign show_top = ((req_q == dws_pkg::REQ_POP) || (req_q == dws_pkg::REQ_PEEK)) && !empty;

	always_comb begin
		sts_nxt = dws_pkg::STS_OK;
		case (req_q)
			dws_pkg::REQ_PUSH: begin
				if (dirty) begin
					sts_nxt = dws_pkg::STS_DIRTY;
				end else if (full) begin
					sts_nxt = dws_pkg::STS_FULL;
				end
			end
			dws_pkg::REQ_POP: begin
				if (empty) begin
					sts_nxt = dws_pkg::STS_EMPTY;
				end
			end
			default: begin
				sts_nxt = dws_pkg::STS_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q  <= s_tuser;
			id_q   <= s_tdata[IW-1:0];
			tag_q  <= s_tdata[IW+TW-1:IW];
			bot_q  <= s_tdata[IW+TW];
			midx_q <= mark_of(s_tdata[IW-1:0]);
		end
	end

	// dirty bitmap, cleared by a sweep after reset, set by a push, cleared by a pop
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 1'b0;
		if (cmd.clear) begin
			ram_we = 1'b1;
		end else if (cmd.exec && push_ok) begin
			ram_we    = 1'b1;
			ram_waddr = midx_q;
			ram_wdata = 1'b1;
		end else if (cmd.exec && pop_ok) begin
			ram_we    = 1'b1;
			ram_waddr = mark_of(ent_q[0][EW-1:TW]);
		end
	end

	dws_ram #(
		.WIDTH (1),
		.DEPTH (ITEM_COUNT)
	) u_marks (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.accept),
		.raddr (mark_of(s_tdata[IW-1:0])),
		.rdata (dirty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// shift stack, top at index zero
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_ent
		always_ff @(posedge clk) begin
			if (cmd.exec && push_ok) begin
				if (bot_q) begin
					if (cnt_q == CW'(i)) begin
						ent_q[i] <= new_ent;
					end
				end else begin
					if (i == 0) begin
						ent_q[i] <= new_ent;
					end else begin
						ent_q[i] <= ent_q[(i == 0) ? 0 : i - 1];
					end
				end
			end else if (cmd.exec && pop_ok) begin
				if (i < STACK_DEPTH - 1) begin
					ent_q[i] <= ent_q[(i < STACK_DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			pushes_q <= '0;
			pops_q   <= '0;
		end else if (cmd.exec) begin
			if (push_ok) begin
				cnt_q    <= cnt_q + 1'b1;
				pushes_q <= pushes_q + 1'b1;
			end else if (pop_ok) begin
				cnt_q  <= cnt_q - 1'b1;
				pops_q <= pops_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_sts_q <= sts_nxt;
			res_id_q  <= show_top ? ent_q[0][EW-1:TW] : '0;
			res_tag_q <= show_top ? ent_q[0][TW-1:0] : '0;
		end
	end

	assign sts.clr_last  = (clr_q == MW'(ITEM_COUNT - 1));
	assign sts.slot_free = !m_valid_q || m_ready;

	assign depth_wide = (CW + DEPTH_PAD)'(cnt_q);
	assign m_valid    = m_valid_q;
	assign m_tuser    = res_sts_q;
	assign m_tdata    = {3'b000, pops_q, pushes_q, depth_wide[DEPTH_PAD-1:0],
		res_tag_q, res_id_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && push_ok |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("accepted push did not grow the stack");

	a_pop_counted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && pop_ok |=> pops_q == $past(pops_q) + 1'b1)
		else $error("successful pop not counted");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && m_valid_q |-> m_ready)
		else $error("pending result overwritten");

	a_no_exec_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !cmd.exec && !cmd.accept)
		else $error("request handled during bitmap sweep");

endmodule

@@ test/dedup_worklist_stack_top_tb.sv @@
`timescale 1ns / 100ps

module dedup_worklist_stack_top_tb;

	localparam int STACK_DEPTH = 64;
	localparam int ITEM_COUNT  = 1024;
	localparam int IDLE_LIMIT  = 4000;
	localparam int RANDOM_REQS = 1580;
	localparam int ID_BITS     = dws_pkg::ID_W;
	localparam int TAG_BITS    = dws_pkg::TAG_W;
	localparam int RES_BITS    = dws_pkg::TOTAL_W;
	localparam logic [dws_pkg::REQ_W-1:0] REQ_NONE = 2'd3;

	typedef struct packed {
		logic [dws_pkg::STS_W-1:0]       status;
		logic [dws_pkg::ID_W-1:0]        item_id;
		logic [dws_pkg::TAG_W-1:0]       circuit_tag;
		logic [dws_pkg::DEPTH_OUT_W-1:0] depth_now;
		logic [dws_pkg::TOTAL_W-1:0]     pushes_total;
		logic [dws_pkg::TOTAL_W-1:0]     pops_total;
	} stack_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [dws_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic [dws_pkg::REQ_W-1:0]       s_axis_tuser;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [dws_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [dws_pkg::STS_W-1:0]       m_axis_tuser;

	// own copy of the stack state
	logic [dws_pkg::ENT_W-1:0]   mdl_stack [STACK_DEPTH];
	int                          mdl_count;
	bit                          mdl_dirty [ITEM_COUNT];
	logic [dws_pkg::TOTAL_W-1:0] mdl_pushes;
	logic [dws_pkg::TOTAL_W-1:0] mdl_pops;

	stack_result_t expected_results [$];
	int            errors = 0;
	bit            send_idle_on = 1'b1;
	bit            recv_idle_on = 1'b1;
	int            recv_hold_ask = 0;

	dedup_worklist_stack_top #(
		.STACK_DEPTH(STACK_DEPTH),
		.ITEM_COUNT (ITEM_COUNT)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 40);
	endfunction

	function automatic stack_result_t predict_request(logic [dws_pkg::REQ_W-1:0] req,
			logic [dws_pkg::ID_W-1:0] id, logic [dws_pkg::TAG_W-1:0] tag, logic bottom);
		stack_result_t r;
		logic [dws_pkg::ENT_W-1:0] e;
		r = '0;
		case (req)
			dws_pkg::REQ_PUSH: begin
				if (mdl_dirty[id]) begin
					r.status = dws_pkg::STS_DIRTY;
				end else if (mdl_count >= STACK_DEPTH) begin
					r.status = dws_pkg::STS_FULL;
				end else begin
					e = {id, tag};
					if (bottom) begin
						for (int i = mdl_count; i > 0; i--)
							mdl_stack[i] = mdl_stack[i-1];
						mdl_stack[0] = e;
					end else begin
						mdl_stack[mdl_count] = e;
					end
					mdl_count++;
					mdl_dirty[id] = 1'b1;
					mdl_pushes++;
				end
			end
			dws_pkg::REQ_POP: begin
				if (mdl_count == 0) begin
					r.status = dws_pkg::STS_EMPTY;
				end else begin
					mdl_count--;
					e = mdl_stack[mdl_count];
					r.item_id = e[dws_pkg::ENT_W-1:dws_pkg::TAG_W];
					r.circuit_tag = e[dws_pkg::TAG_W-1:0];
					mdl_dirty[r.item_id] = 1'b0;
					mdl_pops++;
				end
			end
			dws_pkg::REQ_PEEK: begin
				if (mdl_count != 0) begin
					e = mdl_stack[mdl_count-1];
					r.item_id = e[dws_pkg::ENT_W-1:dws_pkg::TAG_W];
					r.circuit_tag = e[dws_pkg::TAG_W-1:0];
				end
			end
			default: begin
			end
		endcase
		r.status = r.status;
		r.depth_now = mdl_count[dws_pkg::DEPTH_OUT_W-1:0];
		r.pushes_total = mdl_pushes;
		r.pops_total = mdl_pops;
		return r;
	endfunction

	function automatic void check_field(string name, logic [dws_pkg::TOTAL_W-1:0] want,
			logic [dws_pkg::TOTAL_W-1:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic send_req(input logic [dws_pkg::REQ_W-1:0] req,
			input logic [dws_pkg::ID_W-1:0] id, input logic [dws_pkg::TAG_W-1:0] tag,
			input logic bottom);
		int gap;
		gap = send_idle_on ? gap_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, bottom, tag, id};
		s_axis_tuser <= req;
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(predict_request(req, id, tag, bottom));
	endtask

	task automatic test_directed();
		send_req(dws_pkg::REQ_POP, 10'd0, 4'd0, 1'b0);
		send_req(dws_pkg::REQ_PEEK, 10'd0, 4'd0, 1'b0);
		send_req(REQ_NONE, 10'd77, 4'd5, 1'b1);
		send_req(dws_pkg::REQ_PUSH, 10'd0, 4'd0, 1'b0);
		send_req(dws_pkg::REQ_PUSH, 10'd1023, 4'd15, 1'b1);
		send_req(dws_pkg::REQ_PEEK, 10'd1023, 4'd15, 1'b1);
		send_req(dws_pkg::REQ_PUSH, 10'd1023, 4'd3, 1'b0);
		send_req(dws_pkg::REQ_PUSH, 10'd0, 4'd9, 1'b1);
		send_req(dws_pkg::REQ_PUSH, 10'd512, 4'd10, 1'b0);
		send_req(dws_pkg::REQ_POP, 10'd1023, 4'd15, 1'b1);
		send_req(dws_pkg::REQ_POP, 10'd0, 4'd0, 1'b0);
		send_req(dws_pkg::REQ_PEEK, 10'd0, 4'd0, 1'b0);
		send_req(dws_pkg::REQ_POP, 10'd0, 4'd0, 1'b0);
		send_req(dws_pkg::REQ_POP, 10'd0, 4'd0, 1'b0);
		send_req(dws_pkg::REQ_PUSH, 10'd1023, 4'd15, 1'b0);
		send_req(REQ_NONE, 10'd1023, 4'd15, 1'b1);
		send_req(dws_pkg::REQ_POP, 10'd0, 4'd0, 1'b0);
	endtask

	task automatic test_fill_drain();
		logic [dws_pkg::ID_W-1:0] id;
		while (mdl_count < STACK_DEPTH)
			send_req(dws_pkg::REQ_PUSH, ID_BITS'($urandom_range(0, 1023)),
				TAG_BITS'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
		// dirty beats full
		send_req(dws_pkg::REQ_PUSH, mdl_stack[0][dws_pkg::ENT_W-1:dws_pkg::TAG_W],
			TAG_BITS'($urandom_range(0, 15)), 1'b1);
		for (int k = 0; k < 2; k++) begin
			do id = ID_BITS'($urandom_range(0, 1023)); while (mdl_dirty[id]);
			send_req(dws_pkg::REQ_PUSH, id, TAG_BITS'($urandom_range(0, 15)), k[0]);
		end
		send_req(dws_pkg::REQ_PEEK, ID_BITS'($urandom_range(0, 1023)),
			TAG_BITS'($urandom_range(0, 15)), 1'b0);
		while (mdl_count > 0)
			send_req(($urandom_range(0, 4) == 0) ? dws_pkg::REQ_PEEK : dws_pkg::REQ_POP,
				ID_BITS'($urandom_range(0, 1023)), TAG_BITS'($urandom_range(0, 15)),
				1'($urandom_range(0, 1)));
		send_req(dws_pkg::REQ_POP, ID_BITS'($urandom_range(0, 1023)),
			TAG_BITS'($urandom_range(0, 15)), 1'b0);
	endtask

	task automatic test_backpressure();
		send_idle_on = 1'b0;
		recv_hold_ask = 300;
		for (int k = 0; k < 24; k++)
			send_req(($urandom_range(0, 2) == 0) ? dws_pkg::REQ_POP : dws_pkg::REQ_PUSH,
				ID_BITS'($urandom_range(0, 1023)), TAG_BITS'($urandom_range(0, 15)),
				1'($urandom_range(0, 1)));
		send_idle_on = 1'b1;
	endtask

	task automatic test_random_walk();
		int sent;
		int seg_len;
		int push_pct;
		int span;
		int base;
		int r;
		logic [dws_pkg::REQ_W-1:0] req;
		sent = 0;
		while (sent < RANDOM_REQS) begin
			seg_len = $urandom_range(20, 120);
			case ($urandom_range(0, 2))
				0: push_pct = 72;
				1: push_pct = 25;
				default: push_pct = 48;
			endcase
			// narrow pools give many duplicate pushes
			span = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(15, 100);
			base = $urandom_range(0, 1023 - span);
			send_idle_on = ($urandom_range(0, 3) != 0);
			recv_idle_on = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < seg_len; k++) begin
				r = $urandom_range(0, 99);
				if (r < push_pct)
					req = dws_pkg::REQ_PUSH;
				else if (r < 90)
					req = dws_pkg::REQ_POP;
				else if (r < 98)
					req = dws_pkg::REQ_PEEK;
				else
					req = REQ_NONE;
				send_req(req, ID_BITS'(base + $urandom_range(0, span)),
					TAG_BITS'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
				sent++;
			end
		end
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
	endtask

	// result side: checks and random stalls
	initial begin
		stack_result_t want;
		stack_result_t got;
		int stall_cnt;
		int hold_cnt;
		stall_cnt = 0;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tuser;
				got.item_id = m_axis_tdata[9:0];
				got.circuit_tag = m_axis_tdata[13:10];
				got.depth_now = m_axis_tdata[20:14];
				got.pushes_total = m_axis_tdata[52:21];
				got.pops_total = m_axis_tdata[84:53];
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result: expected none actual status %0d id %0d",
						$time, got.status, got.item_id);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", RES_BITS'(want.status), RES_BITS'(got.status));
					check_field("item_id", RES_BITS'(want.item_id), RES_BITS'(got.item_id));
					check_field("circuit_tag", RES_BITS'(want.circuit_tag),
						RES_BITS'(got.circuit_tag));
					check_field("depth_now", RES_BITS'(want.depth_now),
						RES_BITS'(got.depth_now));
					check_field("pushes_total", want.pushes_total, got.pushes_total);
					check_field("pops_total", want.pops_total, got.pops_total);
				end
			end
			if (recv_hold_ask > 0) begin
				hold_cnt = recv_hold_ask;
				recv_hold_ask = 0;
			end
			if (hold_cnt > 0) begin
				m_axis_tready <= 1'b0;
				hold_cnt--;
			end else if (stall_cnt > 0) begin
				m_axis_tready <= 1'b0;
				stall_cnt--;
			end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				stall_cnt = gap_len();
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t timeout: no request moved for %0d cycles", $time, idle_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		mdl_count = 0;
		mdl_pushes = '0;
		mdl_pops = '0;
		foreach (mdl_stack[i])
			mdl_stack[i] = '0;
		foreach (mdl_dirty[i])
			mdl_dirty[i] = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_fill_drain();
		test_backpressure();
		test_random_walk();
		s_axis_tvalid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/dws_pkg.sv
design/dws_ram.sv
design/dws_ctrl.sv
design/dws_datapath.sv
design/dedup_worklist_stack_top.sv
test/dedup_worklist_stack_top_tb.sv
